FILE: hw/rtl/bbfh_pkg.sv
`default_nettype none
package bbfh_pkg;

	localparam int DEPTH = 32;
	localparam int PAYLOAD_BITS = 64;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam int OPCODE_W = 3;
	localparam int ENTRY_W = 64;
	localparam int MAX_W = 6;
	localparam int MAX_RESET = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_BACK    = 3'd1,
		OP_FORWARD = 3'd2,
		OP_CURRENT = 3'd3,
		OP_CRUMBS  = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        waddr;
		logic [PAYLOAD_BITS-1:0] wdata;
		logic                    re;
		logic [IDX_W-1:0]        raddr;
	} ram_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bbfh_if.sv
`default_nettype none
interface bbfh_req_if import bbfh_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ENTRY_W-1:0]  entry_data;

	modport source (output valid, output opcode, output entry_data, input ready);
	modport sink (input valid, input opcode, input entry_data, output ready);
endinterface

interface bbfh_rsp_if import bbfh_pkg::*; ;
	logic               valid;
	logic               ready;
	logic               found;
	logic [ENTRY_W-1:0] entry_out;
	logic               last;
	logic               can_back;
	logic               can_forward;

	modport source (output valid, output found, output entry_out, output last,
		output can_back, output can_forward, input ready);
	modport sink (input valid, input found, input entry_out, input last,
		input can_back, input can_forward, output ready);
endinterface

interface bbfh_cfg_if import bbfh_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [MAX_W-1:0] max_entries;

	modport source (output valid, output max_entries, input ready);
	modport sink (input valid, input max_entries, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bounded_back_forward_history_core.sv
// Bounded back/forward history with a cursor, kept in a ring of DEPTH entries in one
// single-port-read memory. Requests are taken one at a time: push, back, forward,
// current, clear and unknown codes each give a single response, loaded into the
// output register from the emit or data state, and the next request is taken once
// that response has moved into the output register. Breadcrumbs streams one entry
// per cycle while the response port is not stalled, oldest first up to the cursor,
// limited by the memory's single read port; with an empty history it gives a single
// response with no entry. The max_entries register may be written at any time when
// no request is in flight and is clamped to 1..DEPTH; a lowered limit trims the oldest
// entries at the next push.
`default_nettype none
module bounded_back_forward_history_core import bbfh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bbfh_req_if.sink   req,
	bbfh_rsp_if.source rsp,
	bbfh_cfg_if.sink   cfg
);

	ram_req_t                ram_req;
	logic [PAYLOAD_BITS-1:0] ram_rdata;

	bbfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	bbfh_ram #(
		.WIDTH (PAYLOAD_BITS),
		.WORDS (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/bbfh_ram.sv
`default_nettype none
module bbfh_ram #(
	parameter int WIDTH = 64,
	parameter int WORDS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(WORDS)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(WORDS)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bbfh_ctrl.sv
`default_nettype none
module bbfh_ctrl import bbfh_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	bbfh_req_if.sink                     req,
	bbfh_rsp_if.source                   rsp,
	bbfh_cfg_if.sink                     cfg,
	output      ram_req_t                ram_req,
	input  wire logic [PAYLOAD_BITS-1:0] ram_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_DATA = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] base_q, base_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] cursor_q, cursor_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             crumbs_q, crumbs_d;
	logic [MAX_W-1:0] max_q;

	logic                    out_valid_q, out_valid_d;
	logic                    found_q;
	logic [PAYLOAD_BITS-1:0] entry_q;
	logic                    last_q;
	logic                    can_back_q;
	logic                    can_fwd_q;

	logic                    load;
	logic                    load_found;
	logic                    load_last;
	logic                    accept;
	logic                    load_ok;
	logic                    any;
	logic [CNT_W-1:0]        cur_ext;
	logic [CNT_W-1:0]        cur_p1;
	logic [MAX_W:0]          max_ext;
	logic [MAX_W:0]          lim_wide;
	logic [CNT_W-1:0]        lim;
	logic [CNT_W-1:0]        push_n;
	logic [SUM_W-1:0]        push_n1;
	logic                    push_over;
	logic [CNT_W-1:0]        push_excess;
	logic [CNT_W-1:0]        push_count;

	function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_ok   = !out_valid_q || rsp.ready;

	assign any     = (count_q != '0);
	assign cur_ext = CNT_W'(cursor_q);
	assign cur_p1  = cur_ext + CNT_W'(1);

	assign max_ext  = (MAX_W + 1)'(max_q);
	assign lim_wide = (max_q == '0) ? (MAX_W + 1)'(1) :
		(max_ext > (MAX_W + 1)'(DEPTH)) ? (MAX_W + 1)'(DEPTH) : max_ext;
	assign lim = CNT_W'(lim_wide);

	assign push_n      = any ? cur_p1 : '0;
	assign push_n1     = SUM_W'(push_n) + SUM_W'(1);
	assign push_over   = push_n1 > SUM_W'(lim);
	assign push_excess = CNT_W'(push_n1 - SUM_W'(lim));
	assign push_count  = push_over ? lim : CNT_W'(push_n1);

	always_comb begin
		state_d     = state_q;
		base_d      = base_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		idx_d       = idx_q;
		crumbs_d    = crumbs_q;
		load        = 1'b0;
		load_found  = 1'b0;
		load_last   = 1'b1;
		ram_req     = '0;
		ram_req.wdata = req.entry_data[PAYLOAD_BITS-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d  = ST_EMIT;
					crumbs_d = 1'b0;
					case (op_t'(req.opcode))
						OP_PUSH: begin
							ram_req.we    = 1'b1;
							ram_req.waddr = ring_addr(base_q, push_n);
							if (push_over) begin
								base_d = ring_addr(base_q, push_excess);
							end
							count_d  = push_count;
							cursor_d = IDX_W'(push_count - CNT_W'(1));
						end
						OP_BACK: begin
							if (any && cursor_q != '0) begin
								cursor_d      = cursor_q - IDX_W'(1);
								ram_req.re    = 1'b1;
								ram_req.raddr = ring_addr(base_q, CNT_W'(cursor_q - IDX_W'(1)));
								state_d       = ST_DATA;
							end
						end
						OP_FORWARD: begin
							if (any && cur_p1 < count_q) begin
								cursor_d      = IDX_W'(cur_p1);
								ram_req.re    = 1'b1;
								ram_req.raddr = ring_addr(base_q, cur_p1);
								state_d       = ST_DATA;
							end
						end
						OP_CURRENT: begin
							if (any) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = ring_addr(base_q, cur_ext);
								state_d       = ST_DATA;
							end
						end
						OP_CRUMBS: begin
							if (any) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = base_q;
								idx_d         = '0;
								crumbs_d      = 1'b1;
								state_d       = ST_DATA;
							end
						end
						OP_CLEAR: begin
							base_d   = '0;
							count_d  = '0;
							cursor_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (load_ok) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DATA: begin
				load_found = 1'b1;
				load_last  = !crumbs_q || (idx_q == cursor_q);
				if (load_ok) begin
					load = 1'b1;
					if (load_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d         = idx_q + IDX_W'(1);
						ram_req.re    = 1'b1;
						ram_req.raddr = ring_addr(base_q, CNT_W'(idx_q) + CNT_W'(1));
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (load) begin
			out_valid_d = 1'b1;
		end else if (rsp.ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			crumbs_q    <= 1'b0;
			max_q       <= MAX_W'(MAX_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			base_q      <= base_d;
			count_q     <= count_d;
			cursor_q    <= cursor_d;
			idx_q       <= idx_d;
			crumbs_q    <= crumbs_d;
			out_valid_q <= out_valid_d;
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.max_entries;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q    <= load_found;
			entry_q    <= load_found ? ram_rdata : '0;
			last_q     <= load_last;
			can_back_q <= any && (cursor_q != '0);
			can_fwd_q  <= any && (cur_p1 < count_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.entry_out   = ENTRY_W'(entry_q);
	assign rsp.last        = last_q;
	assign rsp.can_back    = can_back_q;
	assign rsp.can_forward = can_fwd_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bbfh_checker.sv
`default_nettype none
module bbfh_checker import bbfh_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic               rsp_found,
	input wire logic [ENTRY_W-1:0] rsp_entry_out,
	input wire logic               rsp_last
);

	// Only one request is in flight, so the block never takes two back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("request accepted in consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_out) && $stable(rsp_last))
	else $error("stalled response changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_entry_out == '0)
	else $error("entry present without found");

	// Only breadcrumbs has more than one response, and each of those carries an entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_found)
	else $error("non-final response without entry");

endmodule

bind bounded_back_forward_history_core bbfh_checker u_bbfh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_found     (rsp.found),
	.rsp_entry_out (rsp.entry_out),
	.rsp_last      (rsp.last)
);
`default_nettype wire

FILE: test/history_checker.sv
`default_nettype none
module history_checker import bbfh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bbfh_req_if      req,
	bbfh_rsp_if      rsp,
	bbfh_cfg_if      cfg,
	output int       fail_count,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic               found;
		logic [ENTRY_W-1:0] entry;
		logic               last;
		logic               can_back;
		logic               can_fwd;
	} nav_result_t;

	logic [PAYLOAD_BITS-1:0] history [DEPTH];
	int unsigned             oldest_slot;
	int unsigned             held;
	int unsigned             cursor;
	logic [MAX_W-1:0]        max_reg;
	nav_result_t             expected_results [$];
	int                      errors = 0;

	assign fail_count = errors;

	function automatic int unsigned kept_limit();
		if (max_reg < 1) return 1;
		if (max_reg > DEPTH) return DEPTH;
		return max_reg;
	endfunction

	function automatic logic [ENTRY_W-1:0] entry_at(input int unsigned pos);
		return ENTRY_W'(history[(oldest_slot + pos) % DEPTH]);
	endfunction

	task automatic queue_result(input logic found, input logic [ENTRY_W-1:0] entry,
		input logic last);
		nav_result_t r;
		r.found = found;
		r.entry = found ? entry : '0;
		r.last = last;
		r.can_back = (held != 0) && (cursor > 0);
		r.can_fwd = (held != 0) && (cursor + 1 < held);
		expected_results = {expected_results, r};
	endtask

	task automatic predict_history(input logic [OPCODE_W-1:0] op,
		input logic [ENTRY_W-1:0] data);
		int unsigned lim;
		int unsigned n;
		case (op)
			OP_PUSH: begin
				lim = kept_limit();
				n = (held != 0) ? cursor + 1 : 0;
				history[(oldest_slot + n) % DEPTH] = data[PAYLOAD_BITS-1:0];
				n++;
				if (n > lim) begin
					oldest_slot = (oldest_slot + n - lim) % DEPTH;
					n = lim;
				end
				held = n;
				cursor = n - 1;
				queue_result(1'b0, '0, 1'b1);
			end
			OP_BACK: begin
				if (held != 0 && cursor > 0) begin
					cursor--;
					queue_result(1'b1, entry_at(cursor), 1'b1);
				end else begin
					queue_result(1'b0, '0, 1'b1);
				end
			end
			OP_FORWARD: begin
				if (held != 0 && cursor + 1 < held) begin
					cursor++;
					queue_result(1'b1, entry_at(cursor), 1'b1);
				end else begin
					queue_result(1'b0, '0, 1'b1);
				end
			end
			OP_CURRENT: begin
				if (held != 0 && cursor < held)
					queue_result(1'b1, entry_at(cursor), 1'b1);
				else
					queue_result(1'b0, '0, 1'b1);
			end
			OP_CRUMBS: begin
				if (held == 0) begin
					queue_result(1'b0, '0, 1'b1);
				end else begin
					n = (cursor + 1 > held) ? held : cursor + 1;
					for (int unsigned i = 0; i < n; i++)
						queue_result(1'b1, entry_at(i), i + 1 == n);
				end
			end
			OP_CLEAR: begin
				oldest_slot = 0;
				held = 0;
				cursor = 0;
				queue_result(1'b0, '0, 1'b1);
			end
			default: begin
				queue_result(1'b0, '0, 1'b1);
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("checker: %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [ENTRY_W-1:0] got,
		input logic [ENTRY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
	endtask

	task automatic check_response();
		nav_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("response with no request pending");
		end else begin
			want = expected_results.pop_front();
			check_field("found", ENTRY_W'(rsp.found), ENTRY_W'(want.found));
			check_field("entry_out", rsp.entry_out, want.entry);
			check_field("last", ENTRY_W'(rsp.last), ENTRY_W'(want.last));
			check_field("can_back", ENTRY_W'(rsp.can_back), ENTRY_W'(want.can_back));
			check_field("can_forward", ENTRY_W'(rsp.can_forward), ENTRY_W'(want.can_fwd));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_slot = 0;
			held = 0;
			cursor = 0;
			max_reg = MAX_W'(MAX_RESET);
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				max_reg = cfg.max_entries;
			if (req.valid && req.ready)
				predict_history(req.opcode, req.entry_data);
			if (rsp.valid && rsp.ready)
				check_response();
			pending <= expected_results.size();
		end
	end

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
	import bbfh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 7;

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;

	bbfh_req_if req ();
	bbfh_rsp_if rsp ();
	bbfh_cfg_if cfg ();

	bounded_back_forward_history_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	history_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_request(input logic [OPCODE_W-1:0] op,
		input logic [ENTRY_W-1:0] data);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.entry_data <= data;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_entries(input logic [MAX_W-1:0] value);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.max_entries <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [ENTRY_W-1:0] random_payload();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_op(input int push_pct);
		if ($urandom_range(0, 99) < push_pct)
			return OP_PUSH;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 19: return OP_BACK;
			6, 7, 8, 9:           return OP_FORWARD;
			10, 11, 12:           return OP_CURRENT;
			13, 14, 15:           return OP_CRUMBS;
			16:                   return OP_CLEAR;
			17:                   return OP_SPARE_LO;
			default:              return OP_SPARE_HI;
		endcase
	endfunction

	initial begin
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			int stall;
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	initial begin
		logic [MAX_W-1:0] phase_limit [PHASES];
		int               phase_items [PHASES];
		int               phase_push [PHASES];

		phase_limit = '{6'd63, 6'd32, 6'd3, 6'd0, 6'd1, 6'd17, 6'd1};
		phase_items = '{38, 12, 10, 8, 8, 8, 6};
		phase_push = '{95, 40, 50, 45, 45, 50, 45};
		phase_limit[PHASES-1] = MAX_W'($urandom_range(1, 63));

		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.opcode <= OP_PUSH;
		req.entry_data <= '0;
		cfg.valid <= 1'b0;
		cfg.max_entries <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every navigation request against an empty history, then the spare codes.
		send_request(OP_CURRENT, '1);
		send_request(OP_BACK, '0);
		send_request(OP_FORWARD, '0);
		send_request(OP_CRUMBS, '0);
		send_request(OP_SPARE_LO, '1);
		send_request(OP_SPARE_HI, '0);
		send_request(OP_PUSH, '0);
		send_request(OP_PUSH, '1);
		send_request(OP_PUSH, 64'hA5A5_A5A5_A5A5_A5A5);
		send_request(OP_PUSH, 64'h5A5A_5A5A_5A5A_5A5A);
		send_request(OP_CRUMBS, '0);
		send_request(OP_BACK, '0);
		send_request(OP_BACK, '0);
		send_request(OP_BACK, '0);
		send_request(OP_BACK, '0);
		send_request(OP_FORWARD, '0);
		send_request(OP_CURRENT, '0);
		// A push from the middle drops everything ahead of the cursor.
		send_request(OP_PUSH, 64'h0123_4567_89AB_CDEF);
		send_request(OP_FORWARD, '0);
		send_request(OP_CRUMBS, '0);
		send_request(OP_CLEAR, '1);
		send_request(OP_CURRENT, '0);

		for (int p = 0; p < PHASES; p++) begin
			write_max_entries(phase_limit[p]);
			calm = (p % 3 == 1);
			for (int i = 0; i < phase_items[p]; i++)
				send_request(pick_op(phase_push[p]), random_payload());
		end
		calm = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
